FILE: hw/rtl/psd_pkg.sv
// Shared types and constants for the point-to-segment distance block.
// No dependencies; imported by point_segment_distance, psd_checker and the testbench.
`default_nettype none
package psd_pkg;
    localparam int CoordW = 16;
    localparam int DistW  = 17;
    localparam logic [DistW-1:0] ThreshReset = 17'd82;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic             is_near;
    } t_res;
endpackage
`default_nettype wire

FILE: hw/rtl/point_segment_distance.sv
// Top level of the point-to-segment distance block.
// Depends on psd_pkg, psd_div_cell and psd_sqrt_cell.
//
//  channel   | direction | handshake          | payload
//  request   | in        | i_start / o_busy   | i_req  (psd_pkg::t_req)
//  result    | out       | o_res_vld strobe   | o_res  (psd_pkg::t_res)
//  config    | in        | i_cfg_we           | i_cfg_data (threshold)
//
// One request is taken every cycle; o_busy is held low.
// A request passes stages 1 to 3, FRAC+2 divider cells, stages A to D, 18
// root cells and the output register; each chain cell settles one bit.
// Reset clears all valid bits and loads the threshold reset value.
// The receiver cannot stall, so no back-pressure exists.
`default_nettype none
module point_segment_distance #(
    parameter int COORD_FRAC_BITS = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire psd_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic [16:0]   i_cfg_data,
    output logic               o_res_vld,
    output psd_pkg::t_res      o_res
);
    import psd_pkg::*;

    localparam int QW    = COORD_FRAC_BITS + 2;     // t in [0, 2^F]
    localparam int RemW  = 36 + COORD_FRAC_BITS;    // dot << F
    localparam int SideW = 4 * 17;
    localparam int SqW   = 36;
    localparam int RW    = 18;

    logic [DistW-1:0] r_thresh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ThreshReset;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end
    assign o_busy = 1'b0;

    // Stage 1: differences.
    logic r1_vld;
    logic signed [16:0] r1_a, r1_b, r1_c, r1_d, r1_ex, r1_ey;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
        r1_a  <= 17'(i_req.point_x) - 17'(i_req.start_x);
        r1_b  <= 17'(i_req.point_y) - 17'(i_req.start_y);
        r1_c  <= 17'(i_req.end_x) - 17'(i_req.start_x);
        r1_d  <= 17'(i_req.end_y) - 17'(i_req.start_y);
        r1_ex <= 17'(i_req.point_x) - 17'(i_req.end_x);
        r1_ey <= 17'(i_req.point_y) - 17'(i_req.end_y);
    end

    // Stage 2: products.
    logic r2_vld;
    logic signed [33:0] r2_ac, r2_bd, r2_cc, r2_dd;
    logic signed [16:0] r2_a, r2_b, r2_c, r2_d, r2_ex, r2_ey;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_ac <= r1_a * r1_c;
        r2_bd <= r1_b * r1_d;
        r2_cc <= r1_c * r1_c;
        r2_dd <= r1_d * r1_d;
        {r2_a, r2_b, r2_c, r2_d, r2_ex, r2_ey} <=
            {r1_a, r1_b, r1_c, r1_d, r1_ex, r1_ey};
    end

    // Stage 3: dot, squared length and case selection.
    logic r3_vld;
    logic signed [34:0] r3_dot;
    logic [34:0] r3_len;
    logic r3_interior;
    logic signed [16:0] r3_dx, r3_dy;
    logic signed [16:0] r3_c, r3_d;
    logic signed [34:0] w_dot;
    logic [34:0] w_len;
    assign w_dot = 35'(r2_ac) + 35'(r2_bd);
    assign w_len = 35'(r2_cc) + 35'(r2_dd);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_dot <= w_dot;
        r3_len <= w_len;
        {r3_c, r3_d} <= {r2_c, r2_d};
        if (w_len == '0 || w_dot < 0) begin
            r3_interior <= 1'b0;
            r3_dx <= r2_a;
            r3_dy <= r2_b;
        end else if (w_dot > $signed(w_len)) begin
            r3_interior <= 1'b0;
            r3_dx <= r2_ex;
            r3_dy <= r2_ey;
        end else begin
            r3_interior <= 1'b1;
            r3_dx <= r2_a;
            r3_dy <= r2_b;
        end
    end

    // Divider chain: t = floor(dot << F / len_sq), one bit per cell.
    logic [QW:0]       c_vld;
    logic [RemW-1:0]   c_rem  [QW+1];
    logic [RemW-1:0]   c_den  [QW+1];
    logic [QW-1:0]     c_quo  [QW+1];
    logic [SideW:0]    c_side [QW+1];
    assign c_vld[0]  = r3_vld;
    assign c_rem[0]  = r3_interior ? RemW'(r3_dot[33:0]) << COORD_FRAC_BITS : '0;
    assign c_den[0]  = r3_interior ? RemW'(r3_len) : RemW'(1);
    assign c_quo[0]  = '0;
    assign c_side[0] = {r3_interior, r3_c, r3_d, r3_dx, r3_dy};

    for (genvar g = 0; g < QW; g++) begin : g_div
        psd_div_cell #(
            .RemW(RemW), .QW(QW), .BitIx(QW-1-g), .SideW(SideW+1)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(c_vld[g]), .i_rem(c_rem[g]), .i_den(c_den[g]),
            .i_quo(c_quo[g]), .i_side(c_side[g]),
            .o_vld(c_vld[g+1]), .o_rem(c_rem[g+1]), .o_den(c_den[g+1]),
            .o_quo(c_quo[g+1]), .o_side(c_side[g+1])
        );
    end

    logic               w_int;
    logic signed [16:0] w_c, w_d, w_dx0, w_dy0;
    assign w_int = c_side[QW][SideW];
    assign {w_c, w_d, w_dx0, w_dy0} = c_side[QW][SideW-1:0];

    // Stage A: t*C and t*D.
    logic rA_vld, rA_int;
    logic signed [QW+17:0] rA_tc, rA_td;
    logic signed [16:0] rA_dx0, rA_dy0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_vld <= 1'b0;
        end else begin
            rA_vld <= c_vld[QW];
        end
        rA_int <= w_int;
        rA_tc  <= $signed({1'b0, c_quo[QW]}) * w_c;
        rA_td  <= $signed({1'b0, c_quo[QW]}) * w_d;
        rA_dx0 <= w_dx0;
        rA_dy0 <= w_dy0;
    end

    // Stage B: rounded offsets and final differences.
    localparam logic signed [QW+17:0] Half = (QW+18)'(1) <<< (COORD_FRAC_BITS-1);
    logic rB_vld;
    logic signed [17:0] rB_dx, rB_dy;
    logic signed [QW+17:0] w_ox, w_oy;
    assign w_ox = (rA_tc + Half) >>> COORD_FRAC_BITS;
    assign w_oy = (rA_td + Half) >>> COORD_FRAC_BITS;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_vld <= 1'b0;
        end else begin
            rB_vld <= rA_vld;
        end
        rB_dx <= rA_int ? 18'(rA_dx0) - 18'(w_ox) : 18'(rA_dx0);
        rB_dy <= rA_int ? 18'(rA_dy0) - 18'(w_oy) : 18'(rA_dy0);
    end

    // Stage C: squares.
    logic rC_vld;
    logic [35:0] rC_xx, rC_yy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_vld <= 1'b0;
        end else begin
            rC_vld <= rB_vld;
        end
        rC_xx <= 36'(rB_dx) * 36'(rB_dx);
        rC_yy <= 36'(rB_dy) * 36'(rB_dy);
    end

    // Stage D: sum of squares.
    logic rD_vld;
    logic [SqW-1:0] rD_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_vld <= 1'b0;
        end else begin
            rD_vld <= rC_vld;
        end
        rD_s <= rC_xx + rC_yy;
    end

    // Square root chain, most significant bit first.
    logic [RW:0]    s_vld;
    logic [SqW-1:0] s_sq   [RW+1];
    logic [RW-1:0]  s_root [RW+1];
    assign s_vld[0]  = rD_vld;
    assign s_sq[0]   = rD_s;
    assign s_root[0] = '0;
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        psd_sqrt_cell #(.SW(SqW), .RW(RW), .BitIx(RW-1-k)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(s_vld[k]), .i_sq(s_sq[k]), .i_root(s_root[k]),
            .o_vld(s_vld[k+1]), .o_sq(s_sq[k+1]), .o_root(s_root[k+1])
        );
    end

    logic [DistW-1:0] w_dist;
    assign w_dist = s_root[RW][RW-1] ? '1 : s_root[RW][DistW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_vld <= 1'b0;
        end else begin
            o_res_vld <= s_vld[RW];
        end
        o_res.distance <= w_dist;
        o_res.is_near  <= (w_dist < r_thresh);
    end
endmodule
`default_nettype wire

FILE: hw/rtl/psd_div_cell.sv
// One restoring-division cell: yields one quotient bit per cycle and passes
// the partial remainder and the side data to the next cell. No package needed.
`default_nettype none
module psd_div_cell #(
    parameter int RemW  = 36,
    parameter int QW    = 16,
    parameter int BitIx = 0,
    parameter int SideW = 68
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic [RemW-1:0]  i_rem,
    input  wire logic [RemW-1:0]  i_den,
    input  wire logic [QW-1:0]    i_quo,
    input  wire logic [SideW-1:0] i_side,
    output logic                  o_vld,
    output logic [RemW-1:0]       o_rem,
    output logic [RemW-1:0]       o_den,
    output logic [QW-1:0]         o_quo,
    output logic [SideW-1:0]      o_side
);
    logic [RemW+QW-1:0] w_trial;
    logic               w_fit;

    // Compare the remainder against the divisor shifted to this bit.
    assign w_trial = {{QW{1'b0}}, i_den} << BitIx;
    assign w_fit   = ({{QW{1'b0}}, i_rem} >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_den  <= i_den;
        o_side <= i_side;
        o_rem  <= w_fit ? i_rem - w_trial[RemW-1:0] : i_rem;
        o_quo  <= i_quo | (QW'(w_fit) << BitIx);
    end
endmodule
`default_nettype wire

FILE: hw/rtl/psd_sqrt_cell.sv
// One square-root cell: decides one root bit per cycle and passes the
// radicand, partial root and valid bit to the next cell. No package needed.
`default_nettype none
module psd_sqrt_cell #(
    parameter int SW    = 36,
    parameter int RW    = 18,
    parameter int BitIx = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [SW-1:0] i_sq,
    input  wire logic [RW-1:0] i_root,
    output logic               o_vld,
    output logic [SW-1:0]      o_sq,
    output logic [RW-1:0]      o_root
);
    logic [RW-1:0]   w_cand;
    logic [2*RW-1:0] w_cand_sq;

    assign w_cand    = i_root | (RW'(1) << BitIx);
    assign w_cand_sq = w_cand * w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_sq   <= i_sq;
        o_root <= ((2*RW)'(i_sq) >= w_cand_sq) ? w_cand : i_root;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/psd_checker.sv
// Port-level checks for point_segment_distance, bound to the top level.
// Depends on psd_pkg.
`default_nettype none
module psd_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_busy,
    input wire logic          o_res_vld,
    input wire psd_pkg::t_res o_res
);
    import psd_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("block refused a request");
    a_no_vld_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_vld) else $error("result strobe after reset");
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> o_res.distance <= 17'd92682)
        else $error("distance out of range");
endmodule

bind point_segment_distance psd_checker u_psd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy),
    .o_res_vld(o_res_vld), .o_res(o_res)
);
`default_nettype wire

FILE: bench/point_segment_distance_tb.sv
// Self-checking testbench for the point-to-segment distance block.
// Depends on psd_pkg and point_segment_distance; checks each result against a predictor.
`default_nettype none
module point_segment_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psd_pkg::*;

    localparam int FracBits   = 14;
    localparam int DrainWait  = 60;
    localparam int IdleLimit  = 3000;
    localparam logic [DistW-1:0] ThreshMax = 17'd92682;

    // Holds the threshold and the queue of distances still to come out.
    class distance_board;
        logic [DistW-1:0] threshold;
        t_res             pending_q[$];
        int               mismatches;

        function void set_threshold(logic [DistW-1:0] value);
            threshold = value;
        endfunction

        function longint unsigned floor_root(longint unsigned s);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= s) r = c;
            end
            return r;
        endfunction

        function void note_request(t_req req);
            longint a, b, c, d, dot, len_sq, dx, dy, t, off_x, off_y, half;
            longint unsigned root;
            t_res res;
            a = longint'(req.point_x) - longint'(req.start_x);
            b = longint'(req.point_y) - longint'(req.start_y);
            c = longint'(req.end_x) - longint'(req.start_x);
            d = longint'(req.end_y) - longint'(req.start_y);
            dot = a * c + b * d;
            len_sq = c * c + d * d;
            half = longint'(1) << (FracBits - 1);
            if (len_sq == 0 || dot < 0) begin
                dx = a;
                dy = b;
            end else if (dot > len_sq) begin
                dx = longint'(req.point_x) - longint'(req.end_x);
                dy = longint'(req.point_y) - longint'(req.end_y);
            end else begin
                t = (dot <<< FracBits) / len_sq;
                // Arithmetic shift floors, which gives round half up here.
                off_x = (t * c + half) >>> FracBits;
                off_y = (t * d + half) >>> FracBits;
                dx = a - off_x;
                dy = b - off_y;
            end
            root = floor_root(longint'(dx * dx + dy * dy));
            if (root > 64'h1FFFF) root = 64'h1FFFF;
            res.distance = root[DistW-1:0];
            res.is_near = (res.distance < threshold);
            pending_q.push_back(res);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: distance %0d is_near %0d",
                             got.distance, got.is_near);
                return;
            end
            want = pending_q.pop_front();
            if (got.distance !== want.distance || got.is_near !== want.is_near) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected distance %0d is_near %0d, got %0d %0d",
                             want.distance, want.is_near, got.distance, got.is_near);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_req             i_req;
    logic             i_cfg_we;
    logic [16:0]      i_cfg_data;
    logic             o_res_vld;
    t_res             o_res;

    distance_board    board;
    int               idle_cycles = 0;

    point_segment_distance #(.COORD_FRAC_BITS(FracBits)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res_vld  (o_res_vld),
        .o_res      (o_res)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Result checker and watchdog; values are those present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_vld) board.check_result(o_res);
            if (o_res_vld || (i_start && !o_busy)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IdleLimit) begin
                $display("point_segment_distance_tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_request(t_req req, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_request(req);
    endtask

    task automatic wait_drain();
        i_start <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [DistW-1:0] value);
        wait_drain();
        repeat (DrainWait) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_threshold(value);
    endtask

    function automatic t_req make_req(logic signed [15:0] px, logic signed [15:0] py,
                                      logic signed [15:0] sx, logic signed [15:0] sy,
                                      logic signed [15:0] ex, logic signed [15:0] ey);
        t_req r;
        r.point_x = px;
        r.point_y = py;
        r.start_x = sx;
        r.start_y = sy;
        r.end_x = ex;
        r.end_y = ey;
        return r;
    endfunction

    function automatic logic signed [15:0] jitter(int base, int span);
        int v;
        v = base + $urandom_range(2 * span) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Mostly points close to a segment so both flag values show up often.
    function automatic t_req random_req();
        t_req r;
        int sx, sy, ex, ey, k;
        case ($urandom_range(3))
            0: r = t_req'({$urandom(), $urandom(), $urandom()});
            1: r = make_req(jitter(0, 300), jitter(0, 300), jitter(0, 300),
                            jitter(0, 300), jitter(0, 300), jitter(0, 300));
            default: begin
                sx = $urandom_range(32000) - 16000;
                sy = $urandom_range(32000) - 16000;
                ex = $urandom_range(32000) - 16000;
                ey = $urandom_range(32000) - 16000;
                k = $urandom_range(10) - 1;
                r = make_req(jitter(sx + (ex - sx) * k / 8, 120),
                             jitter(sy + (ey - sy) * k / 8, 120),
                             16'(sx), 16'(sy), 16'(ex), 16'(ey));
            end
        endcase
        return r;
    endfunction

    initial begin
        board = new();
        board.set_threshold(ThreshReset);
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, degenerate segment, both clamps and the interior.
        send_request(make_req(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                              16'sh7FFF, 16'sh7FFF), 0);
        send_request(make_req(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                              16'sh8000, 16'sh8000), 0);
        send_request(make_req(0, 0, 0, 0, 0, 0), 0);
        send_request(make_req(40, 0, 0, 0, 0, 0), 0);
        send_request(make_req(-500, 30, 0, 0, 1000, 0), 0);
        send_request(make_req(1500, -30, 0, 0, 1000, 0), 0);
        send_request(make_req(500, 50, 0, 0, 1000, 0), 0);
        send_request(make_req(500, 0, 0, 0, 1000, 0), 0);
        send_request(make_req(0, 0, 0, 0, 1000, 0), 0);
        send_request(make_req(1000, 0, 0, 0, 1000, 0), 0);
        send_request(make_req(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                              16'sh7FFF, 16'sh7FFF), 0);
        send_request(make_req(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
                              16'sh7FFF, 16'sh7FFF), 0);
        send_request(make_req(3, 7, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000), 0);
        send_request(make_req(81, 0, 0, 0, 0, 0), 0);
        send_request(make_req(82, 0, 0, 0, 0, 0), 0);

        write_threshold(17'd0);
        for (int n = 0; n < 350; n++) begin
            send_request(random_req(), 34);
            if (n == 150) wait_drain();
        end
        write_threshold(ThreshMax);
        for (int n = 0; n < 350; n++) send_request(random_req(), 61);
        write_threshold(17'($urandom_range(400, 40)));
        for (int n = 0; n < 350; n++) send_request(random_req(), 0);

        i_start <= 1'b0;
        wait_drain();
        repeat (DrainWait) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("point_segment_distance_tb: PASS");
        end else begin
            $display("point_segment_distance_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/psd_pkg.sv
hw/rtl/psd_div_cell.sv
hw/rtl/psd_sqrt_cell.sv
hw/rtl/point_segment_distance.sv
hw/rtl/psd_checker.sv
bench/point_segment_distance_tb.sv
